// ----- sv/qmu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Q16.16 maths unit.
// Depends on nothing; used by qmu_div_step and q16_16_math_unit.
package qmu_pkg;

    // Operation codes carried in the cmd field.
    typedef enum logic [1:0] {
        CMD_MUL = 2'd0,
        CMD_DIV = 2'd1,
        CMD_SIN = 2'd2,
        CMD_COS = 2'd3
    } cmd_t;

    // Default number of entries in the sine table.
    localparam int TABLE_SIZE_DEF = 256;

    // Divider geometry: a 48-bit dividend magnitude, four quotient bits per stage.
    localparam int DIVIDEND_W     = 48;
    localparam int DIV_BITS       = 4;
    localparam int DIV_STAGES     = DIVIDEND_W / DIV_BITS;

    // Pi in Q60 and Q44, and pi/2 in Q60, for building the table and the index scale.
    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
    localparam logic [63:0] PI_Q44      = PI_Q60 >> 16;

    // One pipeline stage's payload.
    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] wide;
        logic [31:0] rem;
        logic [31:0] dvs;
        logic        neg;
        logic        dz;
        logic [31:0] res;
        logic        ovf;
    } stage_t;

    // (a*b) >> 60 for operands below 2^62, built from 32-bit halves.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = {32'h0, a[31:0]};
        ah  = {32'h0, a[63:32]};
        bl  = {32'h0, b[31:0]};
        bh  = {32'h0, b[63:32]};
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + {32'h0, lh[31:0]} + {32'h0, hl[31:0]};
        lo  = {mid[31:0], ll[31:0]};
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return (hi << 4) | (lo >> 60);
    endfunction

endpackage

// ----- sv/qmu_div_step.sv -----
`timescale 1ns / 1ps
// One stage of the restoring divider: retires DIV_BITS quotient bits.
// Depends on qmu_pkg for the divider geometry.
module qmu_div_step (
    input  logic [qmu_pkg::DIVIDEND_W-1:0] wide_in,
    input  logic [31:0]                    rem_in,
    input  logic [31:0]                    dvs,
    output logic [qmu_pkg::DIVIDEND_W-1:0] wide_out,
    output logic [31:0]                    rem_out
);

    // Shift in one dividend bit at a time; the quotient bit replaces it at the bottom.
    always_comb
    begin
        logic [qmu_pkg::DIVIDEND_W-1:0] w;
        logic [31:0]                    r;
        logic [32:0]                    trial;
        w = wide_in;
        r = rem_in;
        for (int i = 0; i < qmu_pkg::DIV_BITS; i++)
        begin
            trial = {r, w[qmu_pkg::DIVIDEND_W-1]};
            w     = {w[qmu_pkg::DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs})
            begin
                trial = trial - {1'b0, dvs};
                w[0]  = 1'b1;
            end
            r = trial[31:0];
        end
        wide_out = w;
        rem_out  = r;
    end

endmodule

// ----- sv/q16_16_math_unit.sv -----
`timescale 1ns / 1ps
// Q16.16 maths unit top level: multiply, divide, sine and cosine in one pipeline.
// Depends on qmu_pkg and qmu_div_step.
//
// Every item passes through DIV_STAGES + 2 register stages (14 with the default
// settings), and one item can be accepted in every cycle while the output is
// not stalled. The depth is set by the divider, which produces its 48-bit
// quotient four bits per stage. Multiply and the table lookup finish in the
// first two stages and then travel with the divider's items so that results
// keep their order. A stage that holds no item lets the stage before it
// advance, so gaps close up while the output is stalled.
// TABLE_SIZE must be a power of two; the sine table is built when the design
// is elaborated.
module q16_16_math_unit #(
    parameter int TABLE_SIZE = qmu_pkg::TABLE_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result,
    output logic               overflow,
    output logic               div_by_zero
);

    localparam int NSTG  = qmu_pkg::DIV_STAGES + 2;
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [63:0] SCALE64 =
        ((64'(TABLE_SIZE) << 51) + qmu_pkg::PI_Q44 / 2) / qmu_pkg::PI_Q44;
    localparam int SCALE_W = $clog2(SCALE64 + 1);
    localparam logic [SCALE_W-1:0] IDX_SCALE = SCALE_W'(SCALE64);
    localparam logic [63:0] COS_OFFSET = 64'(TABLE_SIZE) << 22;
    localparam logic [63:0] TRUNC_BIAS = (64'd1 << 24) - 64'd1;

    // trunc(sin(pi/2 * r / TABLE_SIZE) * 65536) by a Q60 Taylor series.
    function automatic logic [31:0] quarter_sine(input logic [63:0] r);
        logic [63:0] q, rm, f, x, x2, term, sum;
        q    = 64'd0;
        rm   = 64'd0;
        f    = 64'd0;
        x    = 64'd0;
        x2   = 64'd0;
        term = 64'd0;
        sum  = 64'd0;
        if (r == 64'd0)
        begin
            return 32'd0;
        end
        if (r >= 64'(TABLE_SIZE))
        begin
            return 32'd65536;
        end
        q    = (r << 50) / TABLE_SIZE;
        rm   = (r << 50) % TABLE_SIZE;
        f    = (q << 10) + ((rm << 10) / TABLE_SIZE);
        x    = qmu_pkg::mul_q60(qmu_pkg::HALF_PI_Q60, f);
        x2   = qmu_pkg::mul_q60(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k < 20; k++)
        begin
            if (term != 64'd0)
            begin
                term = qmu_pkg::mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
        end
        return 32'(sum >> 44);
    endfunction

    // Table entry i: trunc(sin(2*pi*i/TABLE_SIZE) * 65536).
    function automatic logic [31:0] sine_entry(input int i);
        logic [63:0] u, quad, r;
        logic [31:0] mag;
        u    = 64'(4 * i);
        quad = u / TABLE_SIZE;
        r    = u % TABLE_SIZE;
        mag  = quad[0] ? quarter_sine(64'(TABLE_SIZE) - r) : quarter_sine(r);
        return (quad >= 64'd2) ? -mag : mag;
    endfunction

    // Constant sine table.
    logic [31:0] sine_rom [TABLE_SIZE];
    for (genvar gi = 0; gi < TABLE_SIZE; gi++)
    begin : g_rom
        assign sine_rom[gi] = sine_entry(gi);
    end

    qmu_pkg::stage_t stg_reg  [NSTG];
    qmu_pkg::stage_t stg_next [NSTG];
    logic            vld_reg  [NSTG];
    logic            adv      [NSTG];

    // A stage loads when it is empty or its item moves on.
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    // First stage: the products and the divider's operand preparation.
    logic signed [63:0]         mul_prod;
    logic signed [32+SCALE_W:0] phase_prod;
    logic [31:0]                abs_b;
    logic signed [48:0]         num;
    logic [47:0]                num_mag;

    assign mul_prod   = operand_a * operand_b;
    assign phase_prod = operand_a * $signed({1'b0, IDX_SCALE});
    assign abs_b      = operand_b[31] ? 32'(-operand_b) : operand_b;
    assign num        = {operand_a[31], operand_a, 16'h0} + {18'h0, abs_b[31:1]};
    assign num_mag    = num[48] ? 48'(-num) : num[47:0];

    always_comb
    begin
        stg_next[0].cmd  = qmu_pkg::cmd_t'(cmd);
        stg_next[0].rem  = 32'h0;
        stg_next[0].dvs  = abs_b;
        stg_next[0].neg  = num[48] ^ operand_b[31];
        stg_next[0].dz   = (operand_b == 32'sd0);
        stg_next[0].res  = 32'h0;
        stg_next[0].ovf  = 1'b0;
        case (qmu_pkg::cmd_t'(cmd))
            qmu_pkg::CMD_MUL: stg_next[0].wide = mul_prod;
            qmu_pkg::CMD_DIV: stg_next[0].wide = {16'h0, num_mag};
            qmu_pkg::CMD_SIN: stg_next[0].wide = 64'(phase_prod);
            default:          stg_next[0].wide = 64'(phase_prod) + COS_OFFSET;
        endcase
    end

    // Rounding of the product and the table index, computed in the second stage.
    logic [63:0]      mul_rnd;
    logic [47:0]      mul_res;
    logic [63:0]      phase_t;
    logic [IDX_W-1:0] rom_idx;

    assign mul_rnd = stg_reg[0].wide + 64'd32768;
    assign mul_res = mul_rnd[63:16];
    assign phase_t = stg_reg[0].wide + (stg_reg[0].wide[63] ? TRUNC_BIAS : 64'd0);
    assign rom_idx = phase_t[24 +: IDX_W];

    // Divider stages; the second stage also settles multiply, sine and cosine.
    for (genvar gk = 1; gk <= qmu_pkg::DIV_STAGES; gk++)
    begin : g_div
        logic [qmu_pkg::DIVIDEND_W-1:0] w_out;
        logic [31:0]                    r_out;

        qmu_div_step u_step (
            .wide_in  (stg_reg[gk-1].wide[qmu_pkg::DIVIDEND_W-1:0]),
            .rem_in   (stg_reg[gk-1].rem),
            .dvs      (stg_reg[gk-1].dvs),
            .wide_out (w_out),
            .rem_out  (r_out)
        );

        always_comb
        begin
            stg_next[gk] = stg_reg[gk-1];
            stg_next[gk].wide[qmu_pkg::DIVIDEND_W-1:0] = w_out;
            stg_next[gk].rem = r_out;
            if (gk == 1)
            begin
                case (stg_reg[0].cmd)
                    qmu_pkg::CMD_MUL:
                    begin
                        stg_next[gk].res = mul_res[31:0];
                        stg_next[gk].ovf = !((&mul_res[47:31]) || !(|mul_res[47:31]));
                    end
                    qmu_pkg::CMD_DIV:
                    begin
                        stg_next[gk].res = 32'h0;
                        stg_next[gk].ovf = 1'b0;
                    end
                    default:
                    begin
                        stg_next[gk].res = sine_rom[rom_idx];
                        stg_next[gk].ovf = 1'b0;
                    end
                endcase
            end
        end
    end

    // Last stage: sign and range check of the quotient.
    logic [48:0] quo_s;

    assign quo_s = stg_reg[NSTG-2].neg ? 49'(-{1'b0, stg_reg[NSTG-2].wide[47:0]})
                                       : {1'b0, stg_reg[NSTG-2].wide[47:0]};

    always_comb
    begin
        stg_next[NSTG-1] = stg_reg[NSTG-2];
        if (stg_reg[NSTG-2].cmd == qmu_pkg::CMD_DIV)
        begin
            if (stg_reg[NSTG-2].dz)
            begin
                stg_next[NSTG-1].res = 32'h0;
                stg_next[NSTG-1].ovf = 1'b0;
            end
            else
            begin
                stg_next[NSTG-1].res = quo_s[31:0];
                stg_next[NSTG-1].ovf = !((&quo_s[48:31]) || !(|quo_s[48:31]));
            end
        end
        else
        begin
            stg_next[NSTG-1].dz = 1'b0;
        end
    end

    // Valid bits travel with the items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (adv[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid   = vld_reg[NSTG-1];
    assign result      = stg_reg[NSTG-1].res;
    assign overflow    = stg_reg[NSTG-1].ovf;
    assign div_by_zero = stg_reg[NSTG-1].dz;

    // A zero divisor gives a zero result and no overflow.
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> result == 32'sd0 && !overflow)
        else $error("div_by_zero result not cleared");

    // With the output taken, the pipeline always has room for an item.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled although output is free");

    // The input only stalls behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without an output stall");

endmodule
